### rtl/ack_nak_tracker_assert.svh
// Assertion macros for the acknowledge history tracker.
// Included by the top level; depends on nothing else.
`ifndef ACK_NAK_TRACKER_ASSERT_SVH
`define ACK_NAK_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ANT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ANT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ant_pkg.sv
// Shared types, codes and the CRC-8 byte function of the acknowledge history tracker.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ant_pkg;

  localparam int ENTRIES_DEFAULT = 8;
  localparam logic [7:0] CRC_POLY_RESET = 8'h8C;
  localparam int CRC_CNT_W = 2;
  localparam logic [CRC_CNT_W-1:0] CRC_LAST_BYTE = 2'd2;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [7:0] ACK_CODE_ACK = 8'd1;
  localparam logic [7:0] ACK_CODE_NAK = 8'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RETURN_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLYNOMIAL = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] sent_address;
    logic [7:0] sent_crc;
    logic [7:0] sent_status;
    logic [7:0] ack_first;
    logic [7:0] ack_code;
    logic [7:0] ack_ref_crc;
    logic [7:0] ack_check;
    logic [7:0] lookup_address;
  } in_item_t;

  typedef struct packed {
    logic        lookup_found;
    logic [7:0]  lookup_status;
    logic        ack_crc_ok;
    logic        ack_applied;
    logic [15:0] crc_error_count_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;
  } cfg_wr_t;

  typedef struct packed {
    logic load;
    logic record;
    logic crc_step;
    logic err_inc;
    logic set_ok;
    logic scan_start;
    logic scan_read;
    logic hit;
    logic out_load;
  } ant_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       crc_last;
    logic       crc_ok;
    logic       code_valid;
    logic       hit;
    logic       data_last;
  } ant_status_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data_in,
                                           input logic [7:0] poly);
    logic [7:0] c;
    logic [7:0] d;
    logic       fb;
    c = crc_in;
    d = data_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[0];
      c  = c >> 1;
      if (fb) begin
        c = c ^ poly;
      end
      d = d >> 1;
    end
    return c;
  endfunction

endpackage

### rtl/ant_chan_ifs.sv
// Valid/ready channel interfaces for the input, result and configuration transactions.
// Depends on ant_pkg for the payload types.
interface ant_in_if import ant_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface ant_out_if import ant_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface ant_cfg_if import ant_pkg::*; ();
  logic    valid;
  logic    ready;
  cfg_wr_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

### rtl/ant_ctrl.sv
// Controller state machine of the acknowledge history tracker.
// Depends on ant_pkg; drives the datapath through ant_cmd_t and reads ant_status_t.
module ant_ctrl import ant_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  ant_status_t status,
  output ant_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_CRC, S_CHECK, S_FILL, S_SCAN, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.kind)
          KIND_RECORD: begin
            cmd.record = 1'b1;
            state_nxt  = S_FINISH;
          end
          KIND_ACK: begin
            state_nxt = S_CRC;
          end
          KIND_QUERY: begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_FILL;
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (status.crc_last) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.crc_ok) begin
          cmd.err_inc = 1'b1;
          state_nxt   = S_FINISH;
        end else if (status.code_valid) begin
          cmd.set_ok     = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = S_FILL;
        end else begin
          cmd.set_ok = 1'b1;
          state_nxt  = S_FINISH;
        end
      end
      S_FILL: begin
        cmd.scan_read = 1'b1;
        state_nxt     = S_SCAN;
      end
      S_SCAN: begin
        if (status.hit) begin
          cmd.hit   = 1'b1;
          state_nxt = S_FINISH;
        end else if (status.data_last) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.scan_read = 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/ant_dp.sv
// Datapath of the acknowledge history tracker: history memories, CRC-8 unit, scan
// pointer, error counter, configuration registers and result register. Depends on ant_pkg.
module ant_dp import ant_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  logic        cfg_we,
  input  cfg_wr_t     cfg_wr,
  input  ant_cmd_t    cmd,
  output ant_status_t status,
  output out_item_t   out_item
);

  localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

  in_item_t             item_r;
  logic [7:0]           return_addr_r;
  logic [7:0]           poly_r;
  logic [SLOT_W-1:0]    write_slot_r;
  logic [15:0]          err_cnt_r;
  logic [ENTRIES-1:0]   valid_r;
  logic [7:0]           mem_addr [ENTRIES];
  logic [7:0]           mem_crc  [ENTRIES];
  logic [7:0]           mem_stat [ENTRIES];
  logic [7:0]           crc_r, crc_nxt;
  logic [CRC_CNT_W-1:0] crc_cnt_r;
  logic [SLOT_W-1:0]    scan_slot_r;
  logic [SLOT_W-1:0]    age_r;
  logic [7:0]           rd_addr_r;
  logic [7:0]           rd_crc_r;
  logic [7:0]           rd_stat_r;
  logic                 rd_valid_r;
  logic [SLOT_W-1:0]    data_slot_r;
  logic                 data_last_r;
  logic                 res_found_r;
  logic [7:0]           res_status_r;
  logic                 res_ok_r;
  logic                 res_applied_r;
  out_item_t            out_item_r;

  logic [7:0]        crc_byte;
  logic [7:0]        ent_addr;
  logic [7:0]        ent_crc;
  logic [7:0]        ent_stat;
  logic              hit;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  logic [7:0]        wr_addr;
  logic [7:0]        wr_crc;
  logic [7:0]        wr_stat;
  logic [SLOT_W-1:0] newest_slot;

  always_comb begin
    case (crc_cnt_r)
      2'd0:    crc_byte = item_r.ack_first;
      2'd1:    crc_byte = item_r.ack_code;
      default: crc_byte = item_r.ack_ref_crc;
    endcase
  end

  assign crc_nxt = crc8_byte(crc_r, crc_byte, poly_r);

  // Entries never written read as all zero.
  assign ent_addr = rd_valid_r ? rd_addr_r : 8'd0;
  assign ent_crc  = rd_valid_r ? rd_crc_r  : 8'd0;
  assign ent_stat = rd_valid_r ? rd_stat_r : 8'd0;

  assign hit = (item_r.kind == KIND_QUERY) ? (ent_addr == item_r.lookup_address)
             : ((ent_addr == return_addr_r) && (ent_crc == item_r.ack_ref_crc));

  assign newest_slot = (write_slot_r == '0) ? LAST_SLOT : write_slot_r - 1'b1;

  always_comb begin
    wr_en   = cmd.record || (cmd.hit && (item_r.kind == KIND_ACK));
    wr_slot = write_slot_r;
    wr_addr = item_r.sent_address;
    wr_crc  = item_r.sent_crc;
    wr_stat = item_r.sent_status;
    if (!cmd.record) begin
      wr_slot = data_slot_r;
      wr_addr = ent_addr;
      wr_crc  = ent_crc;
      wr_stat = item_r.ack_code;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_addr[wr_slot] <= wr_addr;
      mem_crc[wr_slot]  <= wr_crc;
      mem_stat[wr_slot] <= wr_stat;
    end
    if (cmd.scan_read) begin
      rd_addr_r <= mem_addr[scan_slot_r];
      rd_crc_r  <= mem_crc[scan_slot_r];
      rd_stat_r <= mem_stat[scan_slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      return_addr_r <= 8'd0;
      poly_r        <= CRC_POLY_RESET;
      write_slot_r  <= '0;
      err_cnt_r     <= 16'd0;
      valid_r       <= '0;
      crc_cnt_r     <= '0;
      scan_slot_r   <= '0;
      age_r         <= '0;
      rd_valid_r    <= 1'b0;
      data_slot_r   <= '0;
      data_last_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_wr.index)
          REG_RETURN_ADDRESS: return_addr_r <= cfg_wr.data;
          REG_CRC_POLYNOMIAL: poly_r        <= cfg_wr.data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        crc_cnt_r <= '0;
      end else if (cmd.crc_step) begin
        crc_cnt_r <= crc_cnt_r + 1'b1;
      end
      if (wr_en) begin
        valid_r[wr_slot] <= 1'b1;
      end
      if (cmd.record) begin
        write_slot_r <= (write_slot_r == LAST_SLOT) ? '0 : write_slot_r + 1'b1;
      end
      if (cmd.err_inc) begin
        err_cnt_r <= err_cnt_r + 16'd1;
      end
      if (cmd.scan_start) begin
        scan_slot_r <= newest_slot;
        age_r       <= '0;
      end else if (cmd.scan_read) begin
        rd_valid_r  <= valid_r[scan_slot_r];
        data_slot_r <= scan_slot_r;
        data_last_r <= (age_r == LAST_SLOT);
        scan_slot_r <= (scan_slot_r == '0) ? LAST_SLOT : scan_slot_r - 1'b1;
        if (age_r != LAST_SLOT) begin
          age_r <= age_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r        <= in_item;
      crc_r         <= 8'd0;
      res_found_r   <= 1'b0;
      res_status_r  <= 8'd0;
      res_ok_r      <= 1'b0;
      res_applied_r <= 1'b0;
    end else begin
      if (cmd.crc_step) begin
        crc_r <= crc_nxt;
      end
      if (cmd.set_ok) begin
        res_ok_r <= 1'b1;
      end
      if (cmd.hit) begin
        if (item_r.kind == KIND_QUERY) begin
          res_found_r  <= 1'b1;
          res_status_r <= ent_stat;
        end else begin
          res_applied_r <= 1'b1;
        end
      end
    end
    if (cmd.out_load) begin
      out_item_r.lookup_found        <= res_found_r;
      out_item_r.lookup_status       <= res_status_r;
      out_item_r.ack_crc_ok          <= res_ok_r;
      out_item_r.ack_applied         <= res_applied_r;
      out_item_r.crc_error_count_out <= err_cnt_r;
    end
  end

  assign status.kind       = item_r.kind;
  assign status.crc_last   = (crc_cnt_r == CRC_LAST_BYTE);
  assign status.crc_ok     = (crc_r == item_r.ack_check);
  assign status.code_valid = (item_r.ack_code == ACK_CODE_ACK)
                          || (item_r.ack_code == ACK_CODE_NAK);
  assign status.hit        = hit;
  assign status.data_last  = data_last_r;

  assign out_item = out_item_r;

endmodule

### rtl/ack_nak_tracker.sv
// Top level of the acknowledge history tracker: joins controller and datapath to the channels.
// Depends on ant_pkg, the channel interfaces, ant_ctrl, ant_dp and the assertion macros.
//
//   channel  direction  carries
//   in_ch    sink       record, acknowledge or query transaction
//   out_ch   source     one result per input transaction
//   cfg_ch   sink       register index and write data, always ready
//
// A record passes the dispatch and finish states only; a query also waits on the scan of the
// history memory, one entry per cycle, up to its first hit; an acknowledge waits on the CRC-8
// unit, a byte per cycle, and after a CRC match with a valid code on the scan. The input is
// ready again the cycle after the result is loaded, so one transaction is in work at once.
// Reset is synchronous and clears the history through per-entry valid bits at once.
// A result waiting in the output register does not stop the next input transaction; the
// work only holds at its end until the output register is free.
`include "ack_nak_tracker_assert.svh"
module ack_nak_tracker import ant_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input logic           clk,
  input logic           rst_n,
  ant_in_if.sink        in_ch,
  ant_out_if.source     out_ch,
  ant_cfg_if.sink       cfg_ch
);

  ant_cmd_t    cmd;
  ant_status_t status;
  logic        in_ready;
  logic        out_valid;
  out_item_t   out_item;

  ant_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ant_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch.payload),
    .cfg_we   (cfg_ch.valid),
    .cfg_wr   (cfg_ch.payload),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid;
  assign out_ch.payload = out_item;
  assign cfg_ch.ready   = 1'b1;

  `ANT_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_ch.valid && in_ready, !in_ready,
    "input accepted while busy")
  `ANT_ASSERT_NOW(a_applied_needs_ok, clk, rst_n, out_valid && out_item.ack_applied,
    out_item.ack_crc_ok, "applied without CRC match")
  `ANT_ASSERT_NOW(a_found_excl_ack, clk, rst_n, out_valid && out_item.lookup_found,
    !out_item.ack_crc_ok && !out_item.ack_applied, "query and acknowledge flags mixed")
  `ANT_ASSERT_NOW(a_status_needs_found, clk, rst_n, out_valid && !out_item.lookup_found,
    out_item.lookup_status == 8'd0, "status without a found entry")

endmodule

### dv/ack_nak_tracker_tb.sv
// Self-checking testbench for the acknowledge history tracker, driven through its channels.
// Depends on ant_pkg, the channel interfaces and the ack_nak_tracker top level.
// A directed table comes first; random phases with varied register settings follow.
module ack_nak_tracker_tb;
  import ant_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_ITEMS = 325;
  localparam int unsigned PHASES = 5;
  localparam int unsigned MAX_REPORTS = 200;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  ant_in_if  in_ch();
  ant_out_if out_ch();
  ant_cfg_if cfg_ch();

  ack_nak_tracker dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic [7:0]  hist_addr [ENTRIES];
  logic [7:0]  hist_crc [ENTRIES];
  logic [7:0]  hist_status [ENTRIES];
  int          next_slot;
  logic [15:0] err_count;
  logic [7:0]  ret_addr;
  logic [7:0]  crc_poly;

  out_item_t   pending_results[$];
  dir_row_t    dir_rows[$];
  logic [7:0]  addr_pool [4];
  logic [7:0]  crc_pool [4];

  bit          quiet;
  bit          hold_req;
  int unsigned rx_gap;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned fail_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data,
                                             input logic [7:0] poly);
    logic [7:0] r;
    logic [7:0] d;
    logic       fb;
    r = crc;
    d = data;
    repeat (8) begin
      fb = r[0] ^ d[0];
      r  = {1'b0, r[7:1]} ^ (fb ? poly : 8'h00);
      d  = d >> 1;
    end
    return r;
  endfunction

  function automatic logic [7:0] ack_crc(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] poly);
    return crc8_update(crc8_update(crc8_update(8'h00, b0, poly), b1, poly), b2, poly);
  endfunction

  function automatic out_item_t track_item(input in_item_t it);
    out_item_t r;
    int        s;
    bit        done;
    r    = '0;
    done = 1'b0;
    case (it.kind)
      KIND_RECORD: begin
        hist_addr[next_slot]   = it.sent_address;
        hist_crc[next_slot]    = it.sent_crc;
        hist_status[next_slot] = it.sent_status;
        next_slot = (next_slot + 1) % ENTRIES;
      end
      KIND_ACK: begin
        if (ack_crc(it.ack_first, it.ack_code, it.ack_ref_crc, crc_poly) == it.ack_check) begin
          r.ack_crc_ok = 1'b1;
          if (it.ack_code == ACK_CODE_ACK || it.ack_code == ACK_CODE_NAK) begin
            for (int age = 0; age < ENTRIES; age++) begin
              s = (next_slot + 2 * ENTRIES - 1 - age) % ENTRIES;
              if (!done && hist_addr[s] == ret_addr && hist_crc[s] == it.ack_ref_crc) begin
                hist_status[s] = it.ack_code;
                r.ack_applied  = 1'b1;
                done = 1'b1;
              end
            end
          end
        end else begin
          err_count = err_count + 16'd1;
        end
      end
      KIND_QUERY: begin
        for (int age = 0; age < ENTRIES; age++) begin
          s = (next_slot + 2 * ENTRIES - 1 - age) % ENTRIES;
          if (!done && hist_addr[s] == it.lookup_address) begin
            r.lookup_found  = 1'b1;
            r.lookup_status = hist_status[s];
            done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    r.crc_error_count_out = err_count;
    return r;
  endfunction

  function automatic in_item_t rec_item(input logic [7:0] a, input logic [7:0] c,
                                        input logic [7:0] st);
    in_item_t it;
    it = '0;
    it.kind = KIND_RECORD;
    it.sent_address = a;
    it.sent_crc = c;
    it.sent_status = st;
    return it;
  endfunction

  function automatic in_item_t ack_item(input logic [7:0] first, input logic [7:0] code,
                                        input logic [7:0] ref_crc, input logic [7:0] check);
    in_item_t it;
    it = '0;
    it.kind = KIND_ACK;
    it.ack_first = first;
    it.ack_code = code;
    it.ack_ref_crc = ref_crc;
    it.ack_check = check;
    return it;
  endfunction

  function automatic in_item_t good_ack(input logic [7:0] first, input logic [7:0] code,
                                        input logic [7:0] ref_crc);
    return ack_item(first, code, ref_crc, ack_crc(first, code, ref_crc, CRC_POLY_RESET));
  endfunction

  function automatic in_item_t query_item(input logic [7:0] a);
    in_item_t it;
    it = '0;
    it.kind = KIND_QUERY;
    it.lookup_address = a;
    return it;
  endfunction

  function automatic out_item_t result_of(input bit found, input logic [7:0] st, input bit ok,
                                          input bit applied, input logic [15:0] cnt);
    out_item_t r;
    r.lookup_found = found;
    r.lookup_status = st;
    r.ack_crc_ok = ok;
    r.ack_applied = applied;
    r.crc_error_count_out = cnt;
    return r;
  endfunction

  function automatic void add_row(input in_item_t it, input bit typed, input out_item_t want);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic void refresh_pools();
    addr_pool[0] = ret_addr;
    for (int i = 1; i < 4; i++) begin
      addr_pool[i] = 8'($urandom);
    end
    for (int i = 0; i < 4; i++) begin
      crc_pool[i] = 8'($urandom);
    end
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    it.kind = 2'($urandom_range(0, 3));
    it.sent_address = 8'($urandom);
    it.sent_crc = 8'($urandom);
    it.sent_status = 8'($urandom);
    it.ack_first = 8'($urandom);
    it.ack_code = 8'($urandom);
    it.ack_ref_crc = 8'($urandom);
    it.ack_check = 8'($urandom);
    it.lookup_address = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return it;
    end else if (pick < 45) begin
      it.kind = KIND_RECORD;
      if ($urandom_range(0, 3) != 0) it.sent_address = addr_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 3) != 0) it.sent_crc = crc_pool[$urandom_range(0, 3)];
    end else if (pick < 75) begin
      it.kind = KIND_ACK;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        it.ack_code = ACK_CODE_ACK;
      end else if (pick < 8) begin
        it.ack_code = ACK_CODE_NAK;
      end
      if ($urandom_range(0, 4) != 0) it.ack_ref_crc = crc_pool[$urandom_range(0, 3)];
      it.ack_check = ack_crc(it.ack_first, it.ack_code, it.ack_ref_crc, crc_poly);
      if ($urandom_range(0, 4) == 0) it.ack_check = it.ack_check ^ (8'd1 << $urandom_range(0, 7));
    end else begin
      it.kind = KIND_QUERY;
      if ($urandom_range(0, 3) != 0) it.lookup_address = addr_pool[$urandom_range(0, 3)];
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   predicted;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.payload <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predicted = track_item(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_wr_t wr;
    wr.index = idx;
    wr.data = data;
    @(negedge clk);
    cfg_ch.payload <= wr;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_RETURN_ADDRESS) begin
      ret_addr = data;
    end else if (idx == REG_CRC_POLYNOMIAL) begin
      crc_poly = data;
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_gap = quiet ? 0 : $urandom_range(0, 10);
      got = out_ch.payload;
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, got);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("lookup_found", 16'(want.lookup_found), 16'(got.lookup_found));
        check_field("lookup_status", 16'(want.lookup_status), 16'(got.lookup_status));
        check_field("ack_crc_ok", 16'(want.ack_crc_ok), 16'(got.ack_crc_ok));
        check_field("ack_applied", 16'(want.ack_applied), 16'(got.ack_applied));
        check_field("crc_error_count_out", want.crc_error_count_out, got.crc_error_count_out);
      end
    end
  end

  initial begin
    in_item_t    tmp;
    logic [7:0]  ret_set [PHASES];
    logic [7:0]  poly_set [PHASES];

    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    rx_gap = 0;
    hold_left = 0;
    cycle_count = 0;
    fail_count = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      hist_addr[i] = '0;
      hist_crc[i] = '0;
      hist_status[i] = '0;
    end
    next_slot = 0;
    err_count = '0;
    ret_addr = '0;
    crc_poly = CRC_POLY_RESET;

    // Cleared entries take part in searches, so address zero is found straight after reset.
    add_row(query_item(8'h00), 1'b1, result_of(1'b1, 8'h00, 1'b0, 1'b0, 16'd0));
    add_row(query_item(8'hFF), 1'b1, result_of(1'b0, 8'h00, 1'b0, 1'b0, 16'd0));
    add_row(ack_item(8'h00, 8'h00, 8'h00, 8'h01), 1'b1,
            result_of(1'b0, 8'h00, 1'b0, 1'b0, 16'd1));
    tmp = '1;
    tmp.kind = KIND_UNUSED;
    add_row(tmp, 1'b1, result_of(1'b0, 8'h00, 1'b0, 1'b0, 16'd1));
    add_row(ack_item(8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
            result_of(1'b0, 8'h00, 1'b1, 1'b0, 16'd1));
    add_row(good_ack(8'h00, ACK_CODE_ACK, 8'h00), 1'b0, '0);
    add_row(query_item(8'h00), 1'b0, '0);
    add_row(rec_item(8'hFF, 8'hFF, 8'hFF), 1'b0, '0);
    add_row(rec_item(8'h00, 8'h00, 8'h00), 1'b0, '0);
    add_row(rec_item(8'hA5, 8'h3C, 8'h80), 1'b0, '0);
    add_row(query_item(8'hFF), 1'b0, '0);
    add_row(query_item(8'hA5), 1'b0, '0);
    add_row(good_ack(8'h5A, ACK_CODE_NAK, 8'h00), 1'b0, '0);
    add_row(query_item(8'h00), 1'b0, '0);
    add_row(good_ack(8'h00, 8'hFF, 8'h00), 1'b0, '0);
    add_row(good_ack(8'hC3, ACK_CODE_ACK, 8'h77), 1'b0, '0);
    tmp = good_ack(8'hFF, 8'hFF, 8'hFF);
    tmp.ack_check = tmp.ack_check ^ 8'h80;
    add_row(tmp, 1'b0, '0);
    add_row(good_ack(8'hFF, ACK_CODE_ACK, 8'h3C), 1'b0, '0);
    for (int i = 1; i <= 6; i++) begin
      add_row(rec_item(8'h12, 8'(i), 8'(i)), 1'b0, '0);
    end
    add_row(query_item(8'hFF), 1'b0, '0);

    ret_set[0] = 8'hFF;  poly_set[0] = 8'h00;
    ret_set[1] = 8'h00;  poly_set[1] = 8'hFF;
    ret_set[2] = 8'h5A;  poly_set[2] = 8'hE0;
    ret_set[3] = 8'($urandom);
    poly_set[3] = 8'($urandom);
    ret_set[4] = 8'($urandom);
    poly_set[4] = CRC_POLY_RESET;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      write_reg(REG_RETURN_ADDRESS, ret_set[p]);
      write_reg(REG_CRC_POLYNOMIAL, poly_set[p]);
      refresh_pools();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 60) quiet = 1'b1;
        if (n == 100) quiet = 1'b0;
        // The result side holds off while the sender keeps offering transactions.
        if (n == 150) begin
          quiet = 1'b1;
          hold_req = 1'b1;
        end
        if (n == 180) quiet = 1'b0;
        if (n == 240) wait_idle();
        send_item(rand_item(), 1'b0, '0);
      end
    end

    quiet = 1'b1;
    send_item(query_item(addr_pool[0]), 1'b0, '0);
    send_item(good_ack(8'($urandom), ACK_CODE_ACK, crc_pool[0]), 1'b0, '0);
    quiet = 1'b0;

    wait_idle();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/ant_pkg.sv
rtl/ant_chan_ifs.sv
rtl/ant_ctrl.sv
rtl/ant_dp.sv
rtl/ack_nak_tracker.sv
dv/ack_nak_tracker_tb.sv
